@@ sv/nixie_frame_refresh_with_acp_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Nixie frame refresh assertion macros
// Concurrent assertion wrappers clocked on clk_i; NFR_ASSERT is disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef NIXIE_FRAME_REFRESH_WITH_ACP_UNIT_ASSERT_SVH
`define NIXIE_FRAME_REFRESH_WITH_ACP_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define NFR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("nfr assertion failed");
`define NFR_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("nfr assertion failed");
`else
`define NFR_ASSERT(lbl, prop)
`define NFR_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

@@ sv/nfr_pkg.sv @@
// ----------------------------------------------------------------------------
// Nixie frame refresh package
// Shared types, register map and frame packing helpers.
// ----------------------------------------------------------------------------
package nfr_pkg;

  localparam int unsigned PADDR_W = 4;
  localparam int unsigned FRAME_W = 64;
  localparam int unsigned FIELD_W = 10;

  typedef enum logic [1:0] {
    MODE_OFF    = 2'd0,
    MODE_EACH   = 2'd1,
    MODE_ROTATE = 2'd2,
    MODE_ALL    = 2'd3
  } nfr_mode_e;

  typedef enum logic [1:0] {
    REG_ACP_MODE  = 2'd0,
    REG_ACP_CYCLE = 2'd1,
    REG_ACP_STEP  = 2'd2,
    REG_REFRESH   = 2'd3
  } nfr_reg_e;

  typedef struct packed {
    logic [3:0] digit0;
    logic [3:0] digit1;
    logic [3:0] digit2;
    logic [3:0] digit3;
    logic [3:0] digit4;
    logic [3:0] digit5;
    logic       dot_left_lower;
    logic       dot_left_upper;
    logic       dot_right_upper;
    logic       dot_right_lower;
  } nfr_in_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic               from_acp;
  } nfr_out_t;

  typedef struct packed {
    nfr_mode_e   acp_mode;
    logic [31:0] acp_cycle_interval;
    logic [31:0] acp_step_interval;
    logic [15:0] refresh_interval;
  } nfr_cfg_t;

  typedef struct packed {
    logic     valid;
    nfr_out_t data;
  } nfr_res_t;

  function automatic logic [FIELD_W-1:0] one_hot(input logic [3:0] v);
    logic [FIELD_W-1:0] r;
    r = '0;
    if (v < 4'd10) begin
      r[v] = 1'b1;
    end
    return r;
  endfunction

  function automatic logic [FRAME_W-1:0] put_digit(input logic [FRAME_W-1:0] f,
                                                   input logic [3:0] d,
                                                   input logic [3:0] v);
    logic [FRAME_W-1:0] r;
    r = f;
    case (d)
      4'd0: r[0 +: FIELD_W] = one_hot(v);
      4'd1: r[10 +: FIELD_W] = one_hot(v);
      4'd2: r[20 +: FIELD_W] = one_hot(v);
      4'd3: r[32 +: FIELD_W] = one_hot(v);
      4'd4: r[42 +: FIELD_W] = one_hot(v);
      4'd5: r[52 +: FIELD_W] = one_hot(v);
      default: r = f;
    endcase
    return r;
  endfunction

  function automatic logic [FRAME_W-1:0] pack_frame(input nfr_in_t it);
    logic [FRAME_W-1:0] r;
    r = '0;
    r[0 +: FIELD_W]  = one_hot(it.digit0);
    r[10 +: FIELD_W] = one_hot(it.digit1);
    r[20 +: FIELD_W] = one_hot(it.digit2);
    r[32 +: FIELD_W] = one_hot(it.digit3);
    r[42 +: FIELD_W] = one_hot(it.digit4);
    r[52 +: FIELD_W] = one_hot(it.digit5);
    r[30] = it.dot_left_lower;
    r[31] = it.dot_left_upper;
    r[62] = it.dot_right_upper;
    r[63] = it.dot_right_lower;
    return r;
  endfunction

  // quotient by ten for a position below 64
  function automatic logic [2:0] div10(input logic [5:0] p);
    logic [2:0] q;
    q = '0;
    for (int i = 1; i < 7; i++) begin
      if (p >= 6'(i * 10)) begin
        q = 3'(i);
      end
    end
    return q;
  endfunction

  // quotient by one hundred for a 10-bit position
  function automatic logic [3:0] div100(input logic [9:0] p);
    logic [3:0] q;
    q = '0;
    for (int i = 1; i < 11; i++) begin
      if (p >= 10'(i * 100)) begin
        q = 4'(i);
      end
    end
    return q;
  endfunction

endpackage

@@ sv/nixie_frame_refresh_with_acp_unit.sv @@
// ----------------------------------------------------------------------------
// Nixie frame refresh with anti-cathode-poisoning
// Packs wanted digits and dots into 64-bit driver frames, throttles refresh
// and injects periodic anti-poisoning sequences.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i): one request per
//   millisecond tick, carrying six digit values and four dot bits.
//   Output channel (out_valid_o/out_ready_i/out_data_o): zero or one frame
//   per request, with from_acp marking anti-poisoning steps.
//   Configuration goes through the APB port; write it only while idle.
//   A request is registered, evaluated combinationally by the engine, and its
//   frame is loaded into the output register when the pipeline advances.
//   Throughput: one request per cycle while the receiver does not stall, set
//   by the state update in the engine between the input and output registers.
//   Reset clears the tick counter, all sequencer state and the valid flags of
//   both registers; configuration returns to mode off, 60000, 100 and 20.
//   When the receiver stalls, the output register holds its frame, one
//   request waits in the input register, and in_ready_o drops.
// ----------------------------------------------------------------------------
`include "nixie_frame_refresh_with_acp_unit_assert.svh"

module nixie_frame_refresh_with_acp_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  nfr_pkg::nfr_in_t            in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output nfr_pkg::nfr_out_t           out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [nfr_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  nfr_pkg::nfr_cfg_t cfg;
  nfr_pkg::nfr_res_t res;
  nfr_pkg::nfr_in_t  in_q;
  nfr_pkg::nfr_out_t out_q;
  logic              in_vq, in_vd;
  logic              out_vq, out_vd;
  logic              adv;

  nfr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  nfr_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (adv),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  assign adv        = in_vq && (!out_vq || out_ready_i);
  assign in_ready_o = !in_vq || adv;

  always_comb begin
    in_vd = in_vq;
    if (in_ready_o) begin
      in_vd = in_valid_i;
    end
    out_vd = out_vq;
    if (adv) begin
      out_vd = res.valid;
    end else if (out_ready_i) begin
      out_vd = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vq  <= 1'b0;
      out_vq <= 1'b0;
    end else begin
      in_vq  <= in_vd;
      out_vq <= out_vd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (adv) begin
      out_q <= res.data;
    end
  end

  assign out_valid_o = out_vq;
  assign out_data_o  = out_q;

  `NFR_ASSERT_ALWAYS(a_ready_when_empty, !out_vq |-> in_ready_o)
  `NFR_ASSERT(a_result_from_advance, (out_vq && !$past(out_vq)) |-> $past(adv))
  `NFR_ASSERT(a_hold_waiting_request, (in_vq && !adv) |=> (in_vq && $stable(in_q)))

endmodule

@@ sv/nfr_regs.sv @@
// ----------------------------------------------------------------------------
// Nixie frame refresh configuration registers
// APB-style register file for ACP mode, intervals and refresh interval.
// ----------------------------------------------------------------------------
module nfr_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [nfr_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output nfr_pkg::nfr_cfg_t           cfg_o
);

  nfr_pkg::nfr_cfg_t cfg_q, cfg_d;
  nfr_pkg::nfr_reg_e reg_sel;
  logic              wr_en;

  assign reg_sel = nfr_pkg::nfr_reg_e'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_sel)
        nfr_pkg::REG_ACP_MODE:  cfg_d.acp_mode = nfr_pkg::nfr_mode_e'(pwdata[1:0]);
        nfr_pkg::REG_ACP_CYCLE: cfg_d.acp_cycle_interval = pwdata;
        nfr_pkg::REG_ACP_STEP:  cfg_d.acp_step_interval = pwdata;
        nfr_pkg::REG_REFRESH:   cfg_d.refresh_interval = pwdata[15:0];
        default:                cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      nfr_pkg::REG_ACP_MODE:  prdata = {30'd0, cfg_q.acp_mode};
      nfr_pkg::REG_ACP_CYCLE: prdata = cfg_q.acp_cycle_interval;
      nfr_pkg::REG_ACP_STEP:  prdata = cfg_q.acp_step_interval;
      nfr_pkg::REG_REFRESH:   prdata = {16'd0, cfg_q.refresh_interval};
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.acp_mode           <= nfr_pkg::MODE_OFF;
      cfg_q.acp_cycle_interval <= 32'd60000;
      cfg_q.acp_step_interval  <= 32'd100;
      cfg_q.refresh_interval   <= 16'd20;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ sv/nfr_engine.sv @@
// ----------------------------------------------------------------------------
// Nixie frame refresh engine
// Per-tick state update: refresh throttle and anti-poisoning sequencer.
// ----------------------------------------------------------------------------
module nfr_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  nfr_pkg::nfr_in_t  item_i,
  input  nfr_pkg::nfr_cfg_t cfg_i,
  output nfr_pkg::nfr_res_t res_o
);

  logic [31:0]                 now_q, now_d;
  logic [nfr_pkg::FRAME_W-1:0] last_frame_q, last_frame_d;
  logic [31:0]                 last_time_q, last_time_d;
  logic                        running_q, running_d;
  logic [31:0]                 next_cycle_q, next_cycle_d;
  logic [31:0]                 next_step_q, next_step_d;
  logic [9:0]                  pos_q, pos_d;

  logic [nfr_pkg::FRAME_W-1:0] data;
  logic                        mode_on;
  logic                        start;
  logic                        run;
  logic [31:0]                 step_t;
  logic                        act;
  logic [31:0]                 elapsed;
  logic [2:0]                  q10;
  logic [3:0]                  r10;
  logic [3:0]                  q100;
  logic [9:0]                  r100;
  logic [3:0]                  q_inc;
  logic [3:0]                  q_wrap;

  assign data    = nfr_pkg::pack_frame(item_i);
  assign mode_on = (cfg_i.acp_mode != nfr_pkg::MODE_OFF);
  assign start   = !running_q && mode_on && (next_cycle_q <= now_q);
  assign run     = running_q || start;
  assign step_t  = start ? now_q : next_step_q;
  assign act     = run && mode_on && (step_t <= now_q);
  assign elapsed = now_q - last_time_q;

  assign q10    = nfr_pkg::div10(pos_q[5:0]);
  assign r10    = 4'(pos_q[5:0] - 6'(q10) * 6'd10);
  assign q100   = nfr_pkg::div100(pos_q);
  assign r100   = pos_q - 10'(q100) * 10'd100;
  assign q_inc  = q100 + 4'd1;
  assign q_wrap = (q_inc >= 4'd6) ? (q_inc - 4'd6) : q_inc;

  always_comb begin
    now_d        = now_q + 32'd1;
    last_frame_d = last_frame_q;
    last_time_d  = last_time_q;
    running_d    = running_q;
    next_cycle_d = next_cycle_q;
    next_step_d  = next_step_q;
    pos_d        = pos_q;
    res_o        = '0;

    if (start) begin
      last_frame_d = ~data;
      next_cycle_d = now_q + cfg_i.acp_cycle_interval;
      running_d    = 1'b1;
      next_step_d  = now_q;
    end

    if (act) begin
      case (cfg_i.acp_mode)
        nfr_pkg::MODE_EACH: begin
          if (pos_q > 10'd59) begin
            pos_d     = '0;
            running_d = 1'b0;
          end else begin
            next_step_d            = step_t + cfg_i.acp_step_interval;
            res_o.valid            = 1'b1;
            res_o.data.frame       = nfr_pkg::put_digit(data, 4'(q10), r10);
            res_o.data.from_acp    = 1'b1;
            pos_d                  = pos_q + 10'd1;
          end
        end
        nfr_pkg::MODE_ROTATE: begin
          next_step_d = step_t + cfg_i.acp_step_interval;
          if (r100 > 10'd9) begin
            pos_d     = 10'(q_wrap) * 10'd100;
            running_d = 1'b0;
          end else begin
            res_o.valid         = 1'b1;
            res_o.data.frame    = nfr_pkg::put_digit(data, q100, r100[3:0]);
            res_o.data.from_acp = 1'b1;
            pos_d               = pos_q + 10'd1;
          end
        end
        nfr_pkg::MODE_ALL: begin
          if (pos_q > 10'd9) begin
            pos_d     = '0;
            running_d = 1'b0;
          end else begin
            next_step_d         = step_t + cfg_i.acp_step_interval;
            res_o.valid         = 1'b1;
            res_o.data.frame    = nfr_pkg::pack_frame('{
              digit0: pos_q[3:0], digit1: pos_q[3:0], digit2: pos_q[3:0],
              digit3: pos_q[3:0], digit4: pos_q[3:0], digit5: pos_q[3:0],
              dot_left_lower: item_i.dot_left_lower,
              dot_left_upper: item_i.dot_left_upper,
              dot_right_upper: item_i.dot_right_upper,
              dot_right_lower: item_i.dot_right_lower});
            res_o.data.from_acp = 1'b1;
            pos_d               = pos_q + 10'd1;
          end
        end
        default: begin
          pos_d = pos_q;
        end
      endcase
    end else if (!run && (data != last_frame_q) &&
                 (elapsed >= {16'd0, cfg_i.refresh_interval})) begin
      last_frame_d        = data;
      last_time_d         = now_q;
      res_o.valid         = 1'b1;
      res_o.data.frame    = data;
      res_o.data.from_acp = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q        <= '0;
      last_frame_q <= '0;
      last_time_q  <= '0;
      running_q    <= 1'b0;
      next_cycle_q <= '0;
      next_step_q  <= '0;
      pos_q        <= '0;
    end else if (step_i) begin
      now_q        <= now_d;
      last_frame_q <= last_frame_d;
      last_time_q  <= last_time_d;
      running_q    <= running_d;
      next_cycle_q <= next_cycle_d;
      next_step_q  <= next_step_d;
      pos_q        <= pos_d;
    end
  end

endmodule
